// ===== design/tia_pkg.sv =====
// Shared types, operation and tag codes for the typed integer ALU.
package tia_pkg;

    localparam int DATA_WIDTH_DEF = 64;

    // Operation codes
    localparam logic [3:0] FN_ADD = 4'd0;
    localparam logic [3:0] FN_SUB = 4'd1;
    localparam logic [3:0] FN_MUL = 4'd2;
    localparam logic [3:0] FN_DIV = 4'd3;
    localparam logic [3:0] FN_MOD = 4'd4;
    localparam logic [3:0] FN_AND = 4'd5;
    localparam logic [3:0] FN_OR  = 4'd6;
    localparam logic [3:0] FN_XOR = 4'd7;
    localparam logic [3:0] FN_EQ  = 4'd8;
    localparam logic [3:0] FN_NE  = 4'd9;
    localparam logic [3:0] FN_LT  = 4'd10;
    localparam logic [3:0] FN_LE  = 4'd11;

    // Type tags
    localparam logic [3:0] TAG_BOOL = 4'd0;
    localparam logic [3:0] TAG_U8   = 4'd1;
    localparam logic [3:0] TAG_I8   = 4'd2;
    localparam logic [3:0] TAG_U16  = 4'd3;
    localparam logic [3:0] TAG_I16  = 4'd4;
    localparam logic [3:0] TAG_U32  = 4'd5;
    localparam logic [3:0] TAG_I32  = 4'd6;
    localparam logic [3:0] TAG_U64  = 4'd7;
    localparam logic [3:0] TAG_I64  = 4'd8;

    // Status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_MISMATCH    = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_DIVZERO     = 2'd3;

    typedef enum logic [1:0] {
        K_PASS = 2'd0,
        K_MUL  = 2'd1,
        K_DIV  = 2'd2,
        K_MOD  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] status;
        logic [3:0] tag;
        logic       neg_q;
        logic       neg_r;
    } t_ctl;

    typedef struct packed {
        logic [3:0]  func;
        logic [3:0]  a_tag;
        logic [63:0] a_value;
        logic [3:0]  b_tag;
        logic [63:0] b_value;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  result_tag;
        logic [63:0] result_value;
        logic [1:0]  status;
    } t_out_word;

endpackage

// ===== design/tia_prep.sv =====
// Input stage: operation decode, status checks, quick results, cell chain setup.
module tia_prep #(
    parameter int DATA_WIDTH = tia_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  tia_pkg::t_in_word     i_word,
    input  logic                  i_next_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output tia_pkg::t_ctl         o_ctl,
    output logic [DATA_WIDTH-1:0] o_r,
    output logic [DATA_WIDTH-1:0] o_s,
    output logic [DATA_WIDTH-1:0] o_d
);
    localparam int W = DATA_WIDTH;

    logic            r_valid;
    tia_pkg::t_ctl   r_ctl, n_ctl;
    logic [W-1:0]    r_r, n_r, r_s, n_s, r_d, n_d;

    logic [3:0]   func, at, bt;
    logic [W-1:0] a, b, ma, mb, sb, x, y, addsub;
    logic         uns, sgn, isint, na, nb;

    assign o_ready = !r_valid || i_next_ready;

    always_comb begin
        func = i_word.func;
        at   = i_word.a_tag;
        bt   = i_word.b_tag;
        a    = i_word.a_value[W-1:0];
        b    = i_word.b_value[W-1:0];
        uns  = (at == tia_pkg::TAG_U8) || (at == tia_pkg::TAG_U16) ||
               (at == tia_pkg::TAG_U32) || (at == tia_pkg::TAG_U64);
        sgn  = (at == tia_pkg::TAG_I8) || (at == tia_pkg::TAG_I16) ||
               (at == tia_pkg::TAG_I32) || (at == tia_pkg::TAG_I64);
        isint = uns || sgn;
        na   = sgn && a[W-1];
        nb   = sgn && b[W-1];
        ma   = na ? (~a + W'(1)) : a;
        mb   = nb ? (~b + W'(1)) : b;
        sb   = {1'b1, {(W-1){1'b0}}};
        x    = sgn ? (a ^ sb) : a;
        y    = sgn ? (b ^ sb) : b;
        addsub = (func == tia_pkg::FN_SUB) ? (a - b) : (a + b);

        n_ctl.kind   = tia_pkg::K_PASS;
        n_ctl.status = tia_pkg::ST_OK;
        n_ctl.tag    = at;
        n_ctl.neg_q  = 1'b0;
        n_ctl.neg_r  = 1'b0;
        n_r = '0;
        n_s = '0;
        n_d = '0;

        if (func > tia_pkg::FN_LE) begin
            n_ctl.status = tia_pkg::ST_UNSUPPORTED;
        end else if (at != bt) begin
            n_ctl.status = tia_pkg::ST_MISMATCH;
        end else begin
            case (func) inside
                tia_pkg::FN_ADD, tia_pkg::FN_SUB: begin
                    if (!isint) n_ctl.status = tia_pkg::ST_UNSUPPORTED;
                    else n_r = addsub;
                end
                tia_pkg::FN_MUL: begin
                    if (!isint) begin
                        n_ctl.status = tia_pkg::ST_UNSUPPORTED;
                    end else begin
                        n_ctl.kind = tia_pkg::K_MUL;
                        n_s = b;
                        n_d = a;
                    end
                end
                tia_pkg::FN_DIV, tia_pkg::FN_MOD: begin
                    if (!isint) begin
                        n_ctl.status = tia_pkg::ST_UNSUPPORTED;
                    end else if (b == '0) begin
                        n_ctl.status = tia_pkg::ST_DIVZERO;
                    end else begin
                        n_ctl.kind  = (func == tia_pkg::FN_DIV) ? tia_pkg::K_DIV
                                                                : tia_pkg::K_MOD;
                        n_ctl.neg_q = na ^ nb;
                        n_ctl.neg_r = na;
                        n_s = ma;
                        n_d = mb;
                    end
                end
                tia_pkg::FN_AND, tia_pkg::FN_OR, tia_pkg::FN_XOR: begin
                    if (at == tia_pkg::TAG_BOOL) begin
                        if (func == tia_pkg::FN_AND)     n_r = W'(a[0] & b[0]);
                        else if (func == tia_pkg::FN_OR) n_r = W'(a[0] | b[0]);
                        else                             n_r = W'(a[0] ^ b[0]);
                    end else if (!isint) begin
                        n_ctl.status = tia_pkg::ST_UNSUPPORTED;
                    end else begin
                        if (func == tia_pkg::FN_AND)     n_r = a & b;
                        else if (func == tia_pkg::FN_OR) n_r = a | b;
                        else                             n_r = a ^ b;
                    end
                end
                default: begin
                    // compares
                    if (!isint) begin
                        n_ctl.status = tia_pkg::ST_UNSUPPORTED;
                    end else begin
                        n_ctl.tag = tia_pkg::TAG_BOOL;
                        if (func == tia_pkg::FN_EQ)      n_r = W'(x == y);
                        else if (func == tia_pkg::FN_NE) n_r = W'(x != y);
                        else if (func == tia_pkg::FN_LT) n_r = W'(x < y);
                        else                             n_r = W'(x <= y);
                    end
                end
            endcase
        end

        if (n_ctl.status != tia_pkg::ST_OK) begin
            n_ctl.kind  = tia_pkg::K_PASS;
            n_ctl.tag   = tia_pkg::TAG_BOOL;
            n_ctl.neg_q = 1'b0;
            n_ctl.neg_r = 1'b0;
            n_r = '0;
            n_s = '0;
            n_d = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl <= n_ctl;
            r_r   <= n_r;
            r_s   <= n_s;
            r_d   <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_r     = r_r;
    assign o_s     = r_s;
    assign o_d     = r_d;

endmodule

// ===== design/tia_cell.sv =====
// One cell of the chain: one shift-add multiply step, one restoring divide step, or a pass-through.
module tia_cell #(
    parameter int DATA_WIDTH = tia_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  tia_pkg::t_ctl         i_ctl,
    input  logic [DATA_WIDTH-1:0] i_r,
    input  logic [DATA_WIDTH-1:0] i_s,
    input  logic [DATA_WIDTH-1:0] i_d,
    input  logic                  i_next_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output tia_pkg::t_ctl         o_ctl,
    output logic [DATA_WIDTH-1:0] o_r,
    output logic [DATA_WIDTH-1:0] o_s,
    output logic [DATA_WIDTH-1:0] o_d
);
    localparam int W = DATA_WIDTH;

    logic          r_valid;
    tia_pkg::t_ctl r_ctl;
    logic [W-1:0]  r_r, n_r, r_s, n_s, r_d;

    logic         is_mul, is_div, fit;
    logic [W:0]   x, y, sum;

    assign o_ready = !r_valid || i_next_ready;

    // r: product accumulator or partial remainder; s: multiplier or dividend/quotient
    always_comb begin
        is_mul = (i_ctl.kind == tia_pkg::K_MUL);
        is_div = (i_ctl.kind == tia_pkg::K_DIV) || (i_ctl.kind == tia_pkg::K_MOD);
        x   = is_mul ? {1'b0, i_r[W-2:0], 1'b0} : {i_r, i_s[W-1]};
        y   = (is_mul && !i_s[W-1]) ? '0 : {1'b0, i_d};
        sum = x + (y ^ {(W+1){is_div}}) + (W+1)'(is_div);
        fit = is_div && !sum[W];
        unique case (i_ctl.kind)
            tia_pkg::K_PASS: begin
                n_r = i_r;
                n_s = i_s;
            end
            tia_pkg::K_MUL: begin
                n_r = sum[W-1:0];
                n_s = {i_s[W-2:0], 1'b0};
            end
            default: begin
                n_r = fit ? sum[W-1:0] : x[W-1:0];
                n_s = {i_s[W-2:0], fit};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl <= i_ctl;
            r_r   <= n_r;
            r_s   <= n_s;
            r_d   <= i_d;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_r     = r_r;
    assign o_s     = r_s;
    assign o_d     = r_d;

endmodule

// ===== design/typed_integer_alu.sv =====
// Top level of the typed integer ALU: input stage, cell chain, output register.
// Takes one word per cycle while o_stall is low and returns one result word per input
// word, in order. The word passes through DATA_WIDTH + 2 registers: the decode stage
// loads at the accepting edge, then DATA_WIDTH cells each resolve one product or
// quotient bit, then the output register. Every word, multiply/divide or not,
// travels the chain, so order is kept. Each stage holds its word until the next
// stage can take it, so bubbles close up under output stall and the input keeps
// flowing while the output register waits until every stage holds a word. Status
// codes: ok, tag mismatch, unsupported type/operation, and divide by zero (zero
// result). Signed overflow wraps; a non-ok status zeroes tag and value.
module typed_integer_alu #(
    parameter int DATA_WIDTH = tia_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  tia_pkg::t_in_word  i_word,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output tia_pkg::t_out_word o_word
);
    localparam int W = DATA_WIDTH;

    // stage 0 is the decode register, stage k+1 the register of cell k
    logic          v   [0:W];
    tia_pkg::t_ctl c   [0:W];
    logic [W-1:0]  sr  [0:W];
    logic [W-1:0]  ss  [0:W];
    logic [W-1:0]  sd  [0:W];
    logic          rdy [0:W+1];

    logic               r_ovalid;
    tia_pkg::t_out_word r_oword, n_oword;
    logic [W-1:0]       post;

    tia_prep #(.DATA_WIDTH(W)) u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_word       (i_word),
        .i_next_ready (rdy[1]),
        .o_ready      (rdy[0]),
        .o_valid      (v[0]),
        .o_ctl        (c[0]),
        .o_r          (sr[0]),
        .o_s          (ss[0]),
        .o_d          (sd[0])
    );

    for (genvar k = 0; k < W; k++) begin : g_cell
        tia_cell #(.DATA_WIDTH(W)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (v[k]),
            .i_ctl        (c[k]),
            .i_r          (sr[k]),
            .i_s          (ss[k]),
            .i_d          (sd[k]),
            .i_next_ready (rdy[k+2]),
            .o_ready      (rdy[k+1]),
            .o_valid      (v[k+1]),
            .o_ctl        (c[k+1]),
            .o_r          (sr[k+1]),
            .o_s          (ss[k+1]),
            .o_d          (sd[k+1])
        );
    end

    assign rdy[W+1] = !r_ovalid || !i_stall;
    assign o_stall  = !rdy[0];

    // final sign fix for signed divide/modulo
    always_comb begin
        unique case (c[W].kind)
            tia_pkg::K_DIV: post = c[W].neg_q ? (~ss[W] + W'(1)) : ss[W];
            tia_pkg::K_MOD: post = c[W].neg_r ? (~sr[W] + W'(1)) : sr[W];
            default:        post = sr[W];
        endcase
        n_oword.result_tag   = c[W].tag;
        n_oword.result_value = 64'(post);
        n_oword.status       = c[W].status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (rdy[W+1]) begin
            r_ovalid <= v[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[W+1] && v[W]) begin
            r_oword <= n_oword;
        end
    end

    assign o_valid = r_ovalid;
    assign o_word  = r_oword;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_word.status != tia_pkg::ST_OK) |->
            (o_word.result_value == 64'd0) && (o_word.result_tag == tia_pkg::TAG_BOOL))
        else $error("non-ok status with nonzero result");

    a_bool_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_word.result_tag == tia_pkg::TAG_BOOL) |->
            (o_word.result_value[63:1] == 63'd0))
        else $error("bool result out of range");

    a_prep_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v[0] && !rdy[1] |=> v[0] && $stable(c[0]))
        else $error("decode stage lost a word");

    a_tail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v[W] && !rdy[W+1] |=> v[W] && $stable(sr[W]))
        else $error("last cell lost a word");
`endif

endmodule
